@@ rtl/fifo_queue_with_delete_core_defines.svh @@
// Assertion macros shared by the queue RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef FIFO_QUEUE_WITH_DELETE_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_DELETE_CORE_DEFINES_SVH

// Same-cycle implication
`define FQD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fqd_pkg.sv @@
`default_nettype none

package fqd_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {
    CMD_ENQ     = 2'd0,
    CMD_DEQ     = 2'd1,
    CMD_DEL     = 2'd2,
    CMD_READOUT = 2'd3
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic off_clear;
    logic off_inc;
    logic rd_en;
    logic wr_enq;
    logic wr_shift;
    logic occ_inc;
    logic occ_dec;
    logic head_inc;
    logic out_load;
    logic out_status;
    logic out_use_data;
    logic out_last;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic is_null;
    logic empty;
    logic full;
    logic match;
    logic at_end;
  } stat_t;

  // Bus handle to stored handle width (zero extend or truncate)
  function automatic handle_t to_handle(input logic [DATA_W-1:0] v);
    logic [HANDLE_BITS+DATA_W-1:0] w;
    w = {{HANDLE_BITS{1'b0}}, v};
    return w[HANDLE_BITS-1:0];
  endfunction

  // Stored handle to bus width (low bits)
  function automatic logic [DATA_W-1:0] from_handle(input handle_t h);
    logic [HANDLE_BITS+DATA_W-1:0] w;
    w = {{DATA_W{1'b0}}, h};
    return w[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/fqd_if.sv @@
`default_nettype none

// Command channel
interface fqd_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [fqd_pkg::DATA_W-1:0]  item_handle;

  modport source (output valid, command, item_handle, input ready);
  modport sink   (input valid, command, item_handle, output ready);
endinterface

// Result channel
interface fqd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [fqd_pkg::DATA_W-1:0]  data_out;
  logic                        entry_valid;
  logic [fqd_pkg::CNT_W-1:0]   entry_count;
  logic                        last;

  modport source (output valid, status, data_out, entry_valid, entry_count, last,
                  input ready);
  modport sink   (input valid, status, data_out, entry_valid, entry_count, last,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/fifo_queue_with_delete_core.sv @@
// Enqueue, dequeue, and any error result: latched in S_IDLE, decoded, then registered in S_FINAL.
// Delete: one stored entry compared or moved per cycle, then the result from S_FINAL.
// Read out: one result per cycle from S_READ while the result channel is free.
// The next input is taken in S_IDLE once the last result of a command is loaded;
// a waiting result does not block it.
// Synchronous active-high rst empties the queue; the entry store itself is not cleared.
`default_nettype none

module fifo_queue_with_delete_core (
  input  wire logic clk,
  input  wire logic rst,
  fqd_in_if.sink    in_ch,
  fqd_out_if.source out_ch
);

  fqd_pkg::ctl_t  ctl;
  fqd_pkg::stat_t st;

  fqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .st        (st)
  );

  fqd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .command     (in_ch.command),
    .item_handle (in_ch.item_handle),
    .status      (out_ch.status),
    .data_out    (out_ch.data_out),
    .entry_valid (out_ch.entry_valid),
    .entry_count (out_ch.entry_count),
    .last        (out_ch.last)
  );

endmodule

`default_nettype wire

@@ rtl/fqd_datapath.sv @@
`default_nettype none

module fqd_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fqd_pkg::ctl_t               ctl,
  output fqd_pkg::stat_t                   st,
  input  wire logic [1:0]                  command,
  input  wire logic [fqd_pkg::DATA_W-1:0]  item_handle,
  output logic                             status,
  output logic [fqd_pkg::DATA_W-1:0]       data_out,
  output logic                             entry_valid,
  output fqd_pkg::cnt_t                    entry_count,
  output logic                             last
);

  `include "fifo_queue_with_delete_core_defines.svh"

  fqd_pkg::handle_t mem [fqd_pkg::DEPTH];
  fqd_pkg::handle_t rd_data;

  fqd_pkg::cmd_t    cmd_reg;
  fqd_pkg::handle_t handle_reg;
  fqd_pkg::idx_t    head;
  fqd_pkg::cnt_t    occ;
  fqd_pkg::idx_t    off;
  fqd_pkg::idx_t    cur_slot;
  fqd_pkg::idx_t    prev_slot;
  fqd_pkg::idx_t    cur_slot_next;
  fqd_pkg::idx_t    tail_slot;
  fqd_pkg::idx_t    wr_addr;
  fqd_pkg::handle_t wr_data;
  logic             wr_en;
  logic [fqd_pkg::CNT_W:0] tail_sum;

  // Slot of the tail: head plus occupancy, wrapped once
  always_comb begin
    tail_sum = (fqd_pkg::CNT_W+1)'(head) + (fqd_pkg::CNT_W+1)'(occ);
    if (tail_sum >= (fqd_pkg::CNT_W+1)'(fqd_pkg::DEPTH)) begin
      tail_sum = tail_sum - (fqd_pkg::CNT_W+1)'(fqd_pkg::DEPTH);
    end
    tail_slot = fqd_pkg::IDX_W'(tail_sum);
  end

  // Walk pointer: slot of the offset being loaded this cycle
  always_comb begin
    cur_slot_next = cur_slot;
    if (ctl.off_clear) begin
      cur_slot_next = head;
    end else if (ctl.off_inc) begin
      if (cur_slot == fqd_pkg::IDX_W'(fqd_pkg::DEPTH - 1)) begin
        cur_slot_next = '0;
      end else begin
        cur_slot_next = cur_slot + fqd_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off       <= '0;
      cur_slot  <= '0;
      prev_slot <= '0;
    end else if (ctl.off_clear) begin
      off       <= '0;
      cur_slot  <= cur_slot_next;
    end else if (ctl.off_inc) begin
      off       <= off + fqd_pkg::IDX_W'(1);
      prev_slot <= cur_slot;
      cur_slot  <= cur_slot_next;
    end
  end

  // Head and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else begin
      if (ctl.head_inc) begin
        if (head == fqd_pkg::IDX_W'(fqd_pkg::DEPTH - 1)) begin
          head <= '0;
        end else begin
          head <= head + fqd_pkg::IDX_W'(1);
        end
      end
      if (ctl.occ_inc) begin
        occ <= occ + fqd_pkg::CNT_W'(1);
      end else if (ctl.occ_dec) begin
        occ <= occ - fqd_pkg::CNT_W'(1);
      end
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_reg    <= fqd_pkg::cmd_t'(command);
      handle_reg <= fqd_pkg::to_handle(item_handle);
    end
  end

  // Entry store: one write port, one registered read port
  assign wr_en   = ctl.wr_enq | ctl.wr_shift;
  assign wr_addr = ctl.wr_enq ? tail_slot : prev_slot;
  assign wr_data = ctl.wr_enq ? handle_reg : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[cur_slot_next];
    end
  end

  // Status to controller
  always_comb begin
    st.cmd     = cmd_reg;
    st.is_null = (handle_reg == '0);
    st.empty   = (occ == '0);
    st.full    = (occ == fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
    st.match   = (rd_data == handle_reg);
    st.at_end  = ((fqd_pkg::CNT_W'(off) + fqd_pkg::CNT_W'(1)) == occ);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= ctl.out_status;
      data_out    <= ctl.out_use_data ? fqd_pkg::from_handle(rd_data) : '0;
      entry_valid <= ctl.out_use_data;
      entry_count <= occ;
      last        <= ctl.out_last;
    end
  end

  `FQD_ASSERT(a_occ_bound, 1'b1, occ <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH), "occupancy above depth")
  `FQD_ASSERT(a_enq_not_full, ctl.wr_enq, !st.full && !st.is_null, "enqueue write when full or null")
  `FQD_ASSERT(a_occ_one_way, 1'b1, !(ctl.occ_inc && ctl.occ_dec), "occupancy up and down together")

endmodule

`default_nettype wire

@@ rtl/fqd_ctrl.sv @@
`default_nettype none

module fqd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fqd_pkg::ctl_t       ctl,
  input  wire fqd_pkg::stat_t st
);

  `include "fifo_queue_with_delete_core_defines.svh"

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SEARCH = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_READ   = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   res_err, res_err_next;
  logic   res_data, res_data_next;
  logic   out_free;
  logic   walk_hit;

  assign out_free = !out_valid || out_ready;
  assign walk_hit = (state == S_SEARCH) && st.match && !st.at_end;

  // Next state and commands
  always_comb begin
    state_next    = state;
    res_err_next  = res_err;
    res_data_next = res_data;
    ctl           = '0;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        res_err_next  = 1'b0;
        res_data_next = 1'b0;
        state_next    = S_FINAL;
        case (st.cmd)
          fqd_pkg::CMD_ENQ: begin
            if (st.is_null || st.full) begin
              res_err_next = 1'b1;
            end else begin
              ctl.wr_enq  = 1'b1;
              ctl.occ_inc = 1'b1;
            end
          end
          fqd_pkg::CMD_DEQ: begin
            if (st.empty) begin
              res_err_next = 1'b1;
            end else begin
              ctl.off_clear = 1'b1;
              ctl.rd_en     = 1'b1;
              ctl.head_inc  = 1'b1;
              ctl.occ_dec   = 1'b1;
              res_data_next = 1'b1;
            end
          end
          fqd_pkg::CMD_DEL: begin
            if (st.is_null || st.empty) begin
              res_err_next = 1'b1;
            end else begin
              ctl.off_clear = 1'b1;
              ctl.rd_en     = 1'b1;
              state_next    = S_SEARCH;
            end
          end
          fqd_pkg::CMD_READOUT: begin
            if (!st.empty) begin
              ctl.off_clear = 1'b1;
              ctl.rd_en     = 1'b1;
              state_next    = S_READ;
            end
          end
          default: begin
            res_err_next = 1'b1;
          end
        endcase
      end
      // Compare one entry per cycle, oldest first
      S_SEARCH: begin
        if (st.match) begin
          res_err_next = 1'b0;
          if (st.at_end) begin
            ctl.occ_dec = 1'b1;
            state_next  = S_FINAL;
          end else begin
            ctl.off_inc = 1'b1;
            ctl.rd_en   = 1'b1;
            state_next  = S_SHIFT;
          end
        end else if (st.at_end) begin
          res_err_next = 1'b1;
          state_next   = S_FINAL;
        end else begin
          ctl.off_inc = 1'b1;
          ctl.rd_en   = 1'b1;
        end
      end
      // Close up: move each later entry down one slot
      S_SHIFT: begin
        ctl.wr_shift = 1'b1;
        if (st.at_end) begin
          ctl.occ_dec = 1'b1;
          state_next  = S_FINAL;
        end else begin
          ctl.off_inc = 1'b1;
          ctl.rd_en   = 1'b1;
        end
      end
      // One entry per transfer
      S_READ: begin
        if (out_free) begin
          ctl.out_load     = 1'b1;
          ctl.out_use_data = 1'b1;
          ctl.out_last     = st.at_end;
          if (st.at_end) begin
            state_next = S_IDLE;
          end else begin
            ctl.off_inc = 1'b1;
            ctl.rd_en   = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          ctl.out_load     = 1'b1;
          ctl.out_status   = res_err;
          ctl.out_use_data = res_data;
          ctl.out_last     = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      res_err   <= 1'b0;
      res_data  <= 1'b0;
    end else begin
      state    <= state_next;
      res_err  <= res_err_next;
      res_data <= res_data_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FQD_ASSERT(a_load_when_free, ctl.out_load, !out_valid || out_ready, "result overwritten")
  `FQD_ASSERT_NEXT(a_shift_entry, walk_hit, state == S_SHIFT, "match did not start close up")
  `FQD_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "stalled result dropped")

endmodule

`default_nettype wire
